// ----- rtl/redirect_route_hash_cache_core_assert.svh -----
// Assertion macros for the redirect route hash cache core.
// Used by files that include this header; needs clk and arst_n in scope.
`ifndef REDIRECT_ROUTE_HASH_CACHE_CORE_ASSERT_SVH
`define REDIRECT_ROUTE_HASH_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RRHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define RRHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rrhc_pkg.sv -----
// Package for the redirect route hash cache: default sizes, word types,
// controller states, control/status structs and the bucket hash.
package rrhc_pkg;

	localparam int BUCKETS_DEF = 128;
	localparam int ENTRIES_DEF = 256;
	localparam int SUM_W       = 10;

	localparam logic CMD_CHECK = 1'b0;
	localparam logic CMD_ADD   = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [31:0] host_address;
		logic [31:0] gateway_address;
	} in_t;

	typedef struct packed {
		logic        found;
		logic [31:0] gateway_result;
		logic        table_full;
	} out_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAD,
		ST_ENTRY
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic in_head;
		logic in_entry;
		logic finish;
	} ctl_t;

	typedef struct packed {
		logic clear_last;
		logic link_zero;
		logic match;
	} sts_t;

	// Sum of the four address bytes
	function automatic logic [SUM_W-1:0] byte_sum(input logic [31:0] addr);
		byte_sum = SUM_W'(addr[7:0]) + SUM_W'(addr[15:8]) +
		           SUM_W'(addr[23:16]) + SUM_W'(addr[31:24]);
	endfunction

endpackage

// ----- rtl/rrhc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/rrhc_ctrl.sv -----
// Controller state machine for the redirect route hash cache.
// Depends on rrhc_pkg for states and control/status structs.
module rrhc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rrhc_pkg::sts_t sts,
	output rrhc_pkg::ctl_t ctl,
	output logic          busy
);

	rrhc_pkg::state_t state_q, state_nxt;

	// State register; reset enters the bucket clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrhc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rrhc_pkg::ST_CLEAR: begin
				if (sts.clear_last) state_nxt = rrhc_pkg::ST_IDLE;
			end
			rrhc_pkg::ST_IDLE: begin
				if (start) state_nxt = rrhc_pkg::ST_HEAD;
			end
			rrhc_pkg::ST_HEAD: begin
				state_nxt = sts.link_zero ? rrhc_pkg::ST_IDLE : rrhc_pkg::ST_ENTRY;
			end
			rrhc_pkg::ST_ENTRY: begin
				if (sts.match || sts.link_zero) state_nxt = rrhc_pkg::ST_IDLE;
			end
			default: state_nxt = rrhc_pkg::ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		ctl      = '0;
		busy     = 1'b1;
		unique case (state_q)
			rrhc_pkg::ST_CLEAR: begin
				ctl.clear = 1'b1;
			end
			rrhc_pkg::ST_IDLE: begin
				busy       = 1'b0;
				ctl.accept = start;
			end
			rrhc_pkg::ST_HEAD: begin
				ctl.in_head = 1'b1;
				ctl.finish  = sts.link_zero;
			end
			rrhc_pkg::ST_ENTRY: begin
				ctl.in_entry = 1'b1;
				ctl.finish   = sts.match || sts.link_zero;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

// ----- rtl/rrhc_dp.sv -----
// Datapath for the redirect route hash cache: item registers, bucket and
// entry RAMs, pool counter, result register. Depends on rrhc_pkg, rrhc_ram.
module rrhc_dp #(
	parameter int BUCKETS = rrhc_pkg::BUCKETS_DEF,
	parameter int ENTRIES = rrhc_pkg::ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rrhc_pkg::ctl_t ctl,
	output rrhc_pkg::sts_t sts,
	input  rrhc_pkg::in_t  item,
	output logic           done,
	output rrhc_pkg::out_t result
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int LW = $clog2(ENTRIES + 1);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int EW = 64 + LW;

	logic          cmd_q;
	logic [31:0]   addr_q;
	logic [31:0]   gw_q;
	logic [BW-1:0] bucket_q;
	logic [LW-1:0] head_q;
	logic [LW-1:0] link_q;
	logic [LW-1:0] used_q;
	logic [BW-1:0] clr_q;
	logic          done_q;
	rrhc_pkg::out_t result_q;

	logic [rrhc_pkg::SUM_W-1:0] sum;
	logic [BW-1:0] bucket_in;
	logic [LW-1:0] head_rd;
	logic [EW-1:0] entry_rd;
	logic [31:0]   e_addr;
	logic [31:0]   e_gw;
	logic [LW-1:0] e_next;
	logic [LW-1:0] cur_link;
	logic [LW-1:0] head_cur;
	logic [LW-1:0] link_m1;
	logic [LW-1:0] link_q_m1;
	logic          hit;
	logic          is_full;
	logic          add_new;
	logic          add_upd;
	logic          b_we;
	logic [BW-1:0] b_waddr;
	logic [LW-1:0] b_wdata;
	logic          e_we;
	logic [IW-1:0] e_waddr;
	logic [EW-1:0] e_wdata;
	rrhc_pkg::out_t result_nxt;

	// Hash the incoming address to its bucket
	assign sum       = rrhc_pkg::byte_sum(item.host_address);
	assign bucket_in = BW'(sum & rrhc_pkg::SUM_W'(BUCKETS - 1));

	// Split the entry word
	assign e_addr = entry_rd[EW-1 -: 32];
	assign e_gw   = entry_rd[LW+31 -: 32];
	assign e_next = entry_rd[LW-1:0];

	// Follow the chain: head link first, then each entry's next link
	assign cur_link  = ctl.in_head ? head_rd : e_next;
	assign head_cur  = ctl.in_head ? head_rd : head_q;
	assign link_m1   = cur_link - LW'(1);
	assign link_q_m1 = link_q - LW'(1);

	assign sts.link_zero  = (cur_link == '0);
	assign sts.match      = (e_addr == addr_q);
	assign sts.clear_last = (clr_q == BW'(BUCKETS - 1));

	// Resolve the item
	assign hit     = ctl.in_entry && sts.match;
	assign is_full = (used_q == LW'(ENTRIES));
	assign add_upd = ctl.finish && (cmd_q == rrhc_pkg::CMD_ADD) && hit;
	assign add_new = ctl.finish && (cmd_q == rrhc_pkg::CMD_ADD) && !hit && !is_full;

	always_comb begin
		result_nxt                = '0;
		result_nxt.found          = hit;
		result_nxt.table_full     = (cmd_q == rrhc_pkg::CMD_ADD) && !hit && is_full;
		if (hit) begin
			result_nxt.gateway_result = (cmd_q == rrhc_pkg::CMD_ADD) ? gw_q : e_gw;
		end else if ((cmd_q == rrhc_pkg::CMD_ADD) && !is_full) begin
			result_nxt.gateway_result = gw_q;
		end
	end

	// Bucket head writes: clearing pass, or link a new entry at the head
	assign b_we    = ctl.clear || add_new;
	assign b_waddr = ctl.clear ? clr_q : bucket_q;
	assign b_wdata = ctl.clear ? '0 : used_q + LW'(1);

	// Entry writes: overwrite a matched entry, or fill the next pool slot
	assign e_we    = add_new || add_upd;
	assign e_waddr = add_upd ? link_q_m1[IW-1:0] : used_q[IW-1:0];
	assign e_wdata = {addr_q, gw_q, (add_upd ? e_next : head_cur)};

	rrhc_ram #(
		.WIDTH(LW),
		.DEPTH(BUCKETS)
	) u_head_ram (
		.clk  (clk),
		.we   (b_we),
		.waddr(b_waddr),
		.wdata(b_wdata),
		.raddr(bucket_in),
		.rdata(head_rd)
	);

	rrhc_ram #(
		.WIDTH(EW),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (e_we),
		.waddr(e_waddr),
		.wdata(e_wdata),
		.raddr(link_m1[IW-1:0]),
		.rdata(entry_rd)
	);

	// Control registers: clear counter, pool count, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			used_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (ctl.clear) clr_q <= clr_q + BW'(1);
			if (add_new) used_q <= used_q + LW'(1);
			done_q <= ctl.finish;
		end
	end

	// Payload registers: hold the item, track the walk, capture the result
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q    <= item.cmd;
			addr_q   <= item.host_address;
			gw_q     <= item.gateway_address;
			bucket_q <= bucket_in;
		end
		if (ctl.in_head) head_q <= head_rd;
		if (ctl.in_head || ctl.in_entry) link_q <= cur_link;
		if (ctl.finish) result_q <= result_nxt;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/redirect_route_hash_cache_core.sv -----
// Redirect route hash cache: a check or add is accepted on start while busy
// is low; the single result word appears for one cycle with done and cannot
// be held off. After start, busy stays high through the head read and then
// each chain entry read up to and including a match, or up to the chain end
// (one entry RAM read per cycle); done is registered and follows the last of
// them. An empty bucket ends after the head read. After reset the bucket head
// RAM is cleared one bucket per cycle, with busy high.
// Depends on rrhc_pkg, rrhc_ctrl, rrhc_dp, rrhc_ram and the assert header.
`include "redirect_route_hash_cache_core_assert.svh"

module redirect_route_hash_cache_core #(
	parameter int BUCKETS = rrhc_pkg::BUCKETS_DEF,
	parameter int ENTRIES = rrhc_pkg::ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rrhc_pkg::in_t  item,
	output logic           done,
	output rrhc_pkg::out_t result
);

	rrhc_pkg::ctl_t ctl;
	rrhc_pkg::sts_t sts;

	rrhc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.ctl   (ctl),
		.busy  (busy)
	);

	rrhc_dp #(
		.BUCKETS(BUCKETS),
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.sts   (sts),
		.item  (item),
		.done  (done),
		.result(result)
	);

	// An accepted word raises busy in the next cycle
	`RRHC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	// The result is shown only once the walk has ended
	`RRHC_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still walking")
	// One result per item: strobes never come back to back
	`RRHC_ASSERT_NEXT(a_done_single, done, !done, "result strobe repeated")
	// A refused add reports nothing else
	`RRHC_ASSERT_NOW(a_full_clean, done && result.table_full,
		!result.found && (result.gateway_result == '0), "full result carries data")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for redirect_route_hash_cache_core: checks and adds of
// redirect routes against a predictor of the chained gateway cache.
// Depends on rrhc_pkg and the core RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rrhc_pkg::*;

	localparam int NUM_BUCKETS  = BUCKETS_DEF;
	localparam int NUM_ENTRIES  = ENTRIES_DEF;
	localparam int HOST_SET     = 400;
	localparam int HOT_HOSTS    = 160;
	localparam int HOT_BUCKETS  = 4;
	localparam int TOTAL_WORDS  = 1550;
	localparam int CYCLE_LIMIT  = 2000000;

	// Gateway cache predictor plus the queue of expected result words
	class route_cache_scoreboard;
		bit [8:0]    chain_head [NUM_BUCKETS];
		bit [31:0]   entry_host [NUM_ENTRIES];
		bit [31:0]   entry_gw   [NUM_ENTRIES];
		bit [8:0]    entry_next [NUM_ENTRIES];
		int unsigned slots_used;
		out_t        expected_answers [$];
		int unsigned error_count;

		function int unsigned bucket_of_host(bit [31:0] host);
			int unsigned sum;
			sum = host[7:0] + host[15:8] + host[23:16] + host[31:24];
			return sum % NUM_BUCKETS;
		endfunction

		// Walk the chain; return entry index + 1 of the match, or 0
		function int unsigned find_link(bit [31:0] host);
			int unsigned link;
			int unsigned steps;
			link = chain_head[bucket_of_host(host)];
			steps = 0;
			while (link != 0 && steps < NUM_ENTRIES) begin
				if (entry_host[link - 1] == host)
					return link;
				link = entry_next[link - 1];
				steps++;
			end
			return 0;
		endfunction

		// Apply an accepted input word and queue the result it causes
		function void note_request(in_t w);
			out_t        ans;
			int unsigned link;
			int unsigned b;
			ans = '0;
			link = find_link(w.host_address);
			if (w.cmd == CMD_CHECK) begin
				if (link != 0) begin
					ans.found = 1'b1;
					ans.gateway_result = entry_gw[link - 1];
				end
			end else if (link != 0) begin
				ans.found = 1'b1;
				entry_gw[link - 1] = w.gateway_address;
				ans.gateway_result = w.gateway_address;
			end else if (slots_used >= NUM_ENTRIES) begin
				ans.table_full = 1'b1;
			end else begin
				b = bucket_of_host(w.host_address);
				entry_host[slots_used] = w.host_address;
				entry_gw[slots_used] = w.gateway_address;
				entry_next[slots_used] = chain_head[b];
				chain_head[b] = 9'(slots_used + 1);
				slots_used++;
				ans.gateway_result = w.gateway_address;
			end
			expected_answers.push_back(ans);
		endfunction

		task report(string what);
			$display("%0t mismatch: %s", $time, what);
			error_count++;
		endtask

		// Compare a result word with the oldest expectation
		task check_answer(out_t got);
			out_t want;
			if (expected_answers.size() == 0) begin
				report("result word with nothing expected");
				return;
			end
			want = expected_answers.pop_front();
			if (got.found !== want.found)
				report($sformatf("found %b, want %b", got.found, want.found));
			if (got.gateway_result !== want.gateway_result)
				report($sformatf("gateway_result %h, want %h",
					got.gateway_result, want.gateway_result));
			if (got.table_full !== want.table_full)
				report($sformatf("table_full %b, want %b", got.table_full, want.table_full));
		endtask

		function int pending();
			return expected_answers.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	in_t  item;
	out_t result;

	route_cache_scoreboard ledger = new();
	logic [31:0] known_hosts [HOST_SET];
	int          idle_stretch;
	int          words_sent;
	int          cycles_run;

	redirect_route_hash_cache_core #(
		.BUCKETS(NUM_BUCKETS),
		.ENTRIES(NUM_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	// Run the clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check every result word as it is strobed
	always @(posedge clk) begin
		if (arst_n && done)
			ledger.check_answer(result);
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Build a host whose byte sum lands in the given bucket
	function automatic logic [31:0] host_in_bucket(int b);
		logic [7:0] b0, b1, b2, b3;
		int s;
		b0 = 8'($urandom);
		b1 = 8'($urandom);
		b2 = 8'($urandom);
		s = b - int'(b0) - int'(b1) - int'(b2);
		b3 = 8'(s & (NUM_BUCKETS - 1));
		b3[7] = 1'($urandom_range(0, 1));
		return {b3, b2, b1, b0};
	endfunction

	// Pick a host that has no entry yet
	function automatic logic [31:0] fresh_host();
		logic [31:0] h;
		h = $urandom;
		while (ledger.find_link(h) != 0)
			h = $urandom;
		return h;
	endfunction

	function automatic in_t random_word();
		in_t w;
		w.cmd = ($urandom_range(0, 1) == 0) ? CMD_CHECK : CMD_ADD;
		if ($urandom_range(0, 4) == 0)
			w.host_address = $urandom;
		else
			w.host_address = known_hosts[$urandom_range(0, HOST_SET - 1)];
		w.gateway_address = $urandom;
		return w;
	endfunction

	// Idle for a drawn gap, then hold start until the word is taken
	task send_word(in_t w);
		int gap;
		if (idle_stretch > 0) begin
			gap = 0;
			idle_stretch--;
		end else begin
			gap = $urandom_range(0, 19);
			if ($urandom_range(0, 15) == 0)
				idle_stretch = $urandom_range(10, 40);
		end
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		item <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		ledger.note_request(w);
		words_sent++;
	endtask

	task issue(logic cmd, logic [31:0] host, logic [31:0] gw);
		in_t w;
		w.cmd = cmd;
		w.host_address = host;
		w.gateway_address = gw;
		send_word(w);
	endtask

	// Drop start and hold off until every expected word has come back
	task drain();
		@(negedge clk);
		start <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		idle_stretch = 0;
		words_sent = 0;
		cycles_run = 0;

		// Mix hosts crowded into a few buckets with spread-out ones
		for (int i = 0; i < HOST_SET; i++) begin
			if (i < HOT_HOSTS)
				known_hosts[i] = host_in_bucket((i % HOT_BUCKETS) * 41);
			else
				known_hosts[i] = $urandom;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty table, extremes of the address and gateway
		issue(CMD_CHECK, 32'h0000_0000, 32'hFFFF_FFFF);
		issue(CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(CMD_ADD,   32'h0000_0000, 32'hFFFF_FFFF);
		issue(CMD_ADD,   32'hFFFF_FFFF, 32'h0000_0000);
		issue(CMD_CHECK, 32'h0000_0000, 32'h0000_0000);
		issue(CMD_CHECK, 32'hFFFF_FFFF, 32'h1234_5678);
		// Grow a chain in bucket zero and walk it
		issue(CMD_ADD,   32'h8000_0000, 32'h1111_1111);
		issue(CMD_ADD,   32'h0080_0000, 32'h2222_2222);
		issue(CMD_ADD,   32'h8080_8000, 32'h3333_3333);
		issue(CMD_CHECK, 32'h0000_0000, 32'h0000_0000);
		issue(CMD_CHECK, 32'h0080_0000, 32'h0000_0000);
		issue(CMD_CHECK, 32'h0000_8080, 32'h0000_0000);
		// Update entries in the middle and at the tail of the chain
		issue(CMD_ADD,   32'h0080_0000, 32'hDEAD_BEEF);
		issue(CMD_CHECK, 32'h0080_0000, 32'h0000_0000);
		issue(CMD_ADD,   32'h0000_0000, 32'h1234_5678);
		issue(CMD_CHECK, 32'h0000_0000, 32'h0000_0000);
		// Empty bucket, and a miss on a shared bucket
		issue(CMD_CHECK, 32'h7F00_0000, 32'h0000_0000);
		issue(CMD_ADD,   32'h0102_0304, 32'h0A0B_0C0D);
		issue(CMD_CHECK, 32'h0403_0201, 32'h0000_0000);

		// Random traffic while the pool fills
		repeat (700)
			send_word(random_word());
		drain();

		// Use up the pool
		while (ledger.slots_used < NUM_ENTRIES)
			issue(CMD_ADD, $urandom, $urandom);

		// Pool exhausted: refused add, then normal checks and updates
		begin
			logic [31:0] h;
			h = fresh_host();
			issue(CMD_ADD,   h, $urandom);
			issue(CMD_CHECK, h, $urandom);
			issue(CMD_ADD,   32'h0000_0000, 32'hA5A5_5A5A);
			issue(CMD_CHECK, 32'h0000_0000, 32'h0000_0000);
			issue(CMD_ADD,   fresh_host(), 32'hFFFF_FFFF);
		end
		drain();

		// Random traffic on the full table
		while (words_sent < TOTAL_WORDS)
			send_word(random_word());
		drain();

		repeat (NUM_ENTRIES + 16) @(posedge clk);
		if (ledger.error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
